// File: rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants for the box frustum cull test block.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int COEF_W = 32;
  localparam int SIZE_W = 31;
  localparam int PROD_W = 64;   // signed 32 x (31 unsigned) product
  localparam int TERM_W = 33;   // sum or difference of two coefficients
  localparam int ACC_W  = 68;   // plane distance, twice its clip value
  localparam int NPLANE = 6;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  // One classified item: a row load or a box test.
  // Loads carry the four coefficients, tests carry the sizes in data[0..2].
  typedef struct packed {
    op_t                          op;
    logic [1:0]                   row;
    logic [3:0][COEF_W-1:0]       data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/bfc_front.sv
// ----------------------------------------------------------------------------
// bfc_front
// Input register: accept items, classify them and hand them to the queue.
// ----------------------------------------------------------------------------
module bfc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [1:0]               in_row_index,
  input  logic signed [31:0]       in_coef_col0,
  input  logic signed [31:0]       in_coef_col1,
  input  logic signed [31:0]       in_coef_col2,
  input  logic signed [31:0]       in_coef_col3,
  input  logic [30:0]              in_size_x,
  input  logic [30:0]              in_size_y,
  input  logic [30:0]              in_size_z,
  input  bfc_pkg::q_stat_t         q_stat,
  output logic                     push,
  output bfc_pkg::cmd_t            push_cmd
);

  logic           f_valid_r, f_valid_nxt;
  bfc_pkg::cmd_t  f_cmd_r, f_cmd_nxt;
  logic           accept;

  assign push     = f_valid_r && !q_stat.full;
  assign in_stall = f_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = f_cmd_r;

  always_comb begin
    f_cmd_nxt     = f_cmd_r;
    f_valid_nxt   = f_valid_r;
    if (push) begin
      f_valid_nxt = 1'b0;
    end
    if (accept) begin
      f_valid_nxt = 1'b1;
      if (bfc_pkg::op_t'(in_operation) == bfc_pkg::OP_TEST) begin
        f_cmd_nxt.op      = bfc_pkg::OP_TEST;
        f_cmd_nxt.row     = 2'd0;
        f_cmd_nxt.data[0] = {1'b0, in_size_x};
        f_cmd_nxt.data[1] = {1'b0, in_size_y};
        f_cmd_nxt.data[2] = {1'b0, in_size_z};
        f_cmd_nxt.data[3] = '0;
      end else begin
        f_cmd_nxt.op      = bfc_pkg::OP_LOAD;
        f_cmd_nxt.row     = in_row_index;
        f_cmd_nxt.data[0] = in_coef_col0;
        f_cmd_nxt.data[1] = in_coef_col1;
        f_cmd_nxt.data[2] = in_coef_col2;
        f_cmd_nxt.data[3] = in_coef_col3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_cmd_r <= f_cmd_nxt;
  end

endmodule

// File: rtl/bfc_queue.sv
// ----------------------------------------------------------------------------
// bfc_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bfc_queue #(
  parameter int DEPTH = bfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfc_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output bfc_pkg::cmd_t     head,
  output bfc_pkg::q_stat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfc_pkg::cmd_t     mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/bfc_back.sv
// ----------------------------------------------------------------------------
// bfc_back
// Matrix store and test pipeline: multiply, plane terms, magnitudes, sign.
// ----------------------------------------------------------------------------
module bfc_back #(
  parameter int FRAC_BITS = bfc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfc_pkg::cmd_t     head,
  input  bfc_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_visible,
  output logic [5:0]        out_plane_mask
);

  localparam int PW = bfc_pkg::PROD_W;
  localparam int TW = bfc_pkg::TERM_W;
  localparam int AW = bfc_pkg::ACC_W;
  localparam int NP = bfc_pkg::NPLANE;

  logic signed [31:0]   mat_r [4][4];

  logic                 v1_r, v2_r, v3_r;
  logic signed [PW-1:0] prod_r [4][3];
  logic signed [31:0]   trans_r [4];
  logic signed [PW-1:0] pt_r [NP][3];
  logic signed [TW-1:0] tt2_r [NP];
  logic [PW-1:0]        mag_r [NP][3];
  logic signed [TW-1:0] tt3_r [NP];
  logic                 out_valid_r;
  logic [5:0]           mask_r, mask_nxt;

  logic                 en, take_test;
  logic signed [AW-1:0] acc [NP];

  // Hold the whole pipe while the result register is full and stalled.
  assign en        = !out_valid_r || !out_stall;
  assign pop       = !q_stat.empty && ((head.op == bfc_pkg::OP_LOAD) || en);
  assign take_test = pop && (head.op == bfc_pkg::OP_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 4; j++) begin
          mat_r[r][j] <= '0;
        end
      end
    end else if (pop && (head.op == bfc_pkg::OP_LOAD)) begin
      for (int j = 0; j < 4; j++) begin
        mat_r[head.row][j] <= head.data[j];
      end
    end
  end

  // Distance to each plane at its best corner, twice scaled:
  // t * 2^(F+1) + sum |row3_j*s_j -/+ rowa_j*s_j| ; inside when >= 0.
  always_comb begin
    for (int k = 0; k < NP; k++) begin
      acc[k] = (AW'(tt3_r[k]) <<< (FRAC_BITS + 1))
             + AW'(mag_r[k][0]) + AW'(mag_r[k][1]) + AW'(mag_r[k][2]);
      mask_nxt[k] = !acc[k][AW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= take_test;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[r][j] <= mat_r[r][j] * $signed(head.data[j]);
        end
        trans_r[r] <= mat_r[r][3];
      end
      for (int k = 0; k < NP; k++) begin
        for (int j = 0; j < 3; j++) begin
          if ((k % 2) == 0) begin
            pt_r[k][j] <= prod_r[3][j] - prod_r[k / 2][j];
          end else begin
            pt_r[k][j] <= prod_r[3][j] + prod_r[k / 2][j];
          end
          mag_r[k][j] <= pt_r[k][j][PW-1] ? PW'(-pt_r[k][j]) : PW'(pt_r[k][j]);
        end
        if ((k % 2) == 0) begin
          tt2_r[k] <= TW'(trans_r[3]) - TW'(trans_r[k / 2]);
        end else begin
          tt2_r[k] <= TW'(trans_r[3]) + TW'(trans_r[k / 2]);
        end
        tt3_r[k] <= tt2_r[k];
      end
      mask_r <= mask_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plane_mask = mask_r;
  assign out_visible    = &mask_r;

endmodule

// File: rtl/box_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// box_frustum_cull_test
// Conservative clip-space frustum test of an origin-centered box.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | operation, row_index, coef_col0..3, size_x..z
//  out     | out_valid/out_stall| visible, plane_mask (one per test item)
//
// One item per cycle sustained while nothing is stalled. A test item passes the
// input register and the queue, then the multiply, plane-term and magnitude
// registers, and its sign mask lands in the result register; a load item
// writes its matrix row as it leaves the queue and makes no result.
// Synchronous active-low reset empties the pipe and the queue and zeroes the
// matrix in the same cycle.
// A stalled result holds the back pipe; the queue keeps taking items until it
// fills, then in_stall rises. Loads leave the queue even while the back holds.
//
module box_frustum_cull_test #(
  parameter int FRAC_BITS   = bfc_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = bfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_coef_col0,
  input  logic signed [31:0] in_coef_col1,
  input  logic signed [31:0] in_coef_col2,
  input  logic signed [31:0] in_coef_col3,
  input  logic [30:0]        in_size_x,
  input  logic [30:0]        in_size_y,
  input  logic [30:0]        in_size_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible,
  output logic [5:0]         out_plane_mask
);

  bfc_pkg::q_stat_t  q_stat;
  bfc_pkg::cmd_t     push_cmd;
  bfc_pkg::cmd_t     head;
  logic              push;
  logic              pop;

  // Register and classify incoming items.
  bfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_row_index (in_row_index),
    .in_coef_col0 (in_coef_col0),
    .in_coef_col1 (in_coef_col1),
    .in_coef_col2 (in_coef_col2),
    .in_coef_col3 (in_coef_col3),
    .in_size_x    (in_size_x),
    .in_size_y    (in_size_y),
    .in_size_z    (in_size_z),
    .q_stat       (q_stat),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Decouple the front from the back; order of loads and tests is kept.
  bfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Apply loads to the matrix, run tests through the plane pipeline.
  bfc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_visible    (out_visible),
    .out_plane_mask (out_plane_mask)
  );

endmodule

// File: rtl/bfc_checker.sv
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks for the box frustum cull test block.
// ----------------------------------------------------------------------------
module bfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_visible,
  input logic [5:0] out_plane_mask
);

  // Reset empties the block: no result and no back-pressure right after.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("result or stall present after reset");

  // Visible means every plane has an inside corner.
  a_visible_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_visible == (out_plane_mask == 6'h3f)))
    else $error("visible disagrees with plane mask");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_plane_mask) && $stable(out_visible)))
    else $error("result changed while stalled");

endmodule

bind box_frustum_cull_test bfc_checker u_bfc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_visible    (out_visible),
  .out_plane_mask (out_plane_mask)
);

// File: test/box_frustum_cull_test_tb.sv
// ============================================================================
// box_frustum_cull_test_tb
// Self-checking bench for the clip-space box frustum cull block.
// Row loads and box tests are queued up front, fed through a bursty driver,
// and every box verdict is predicted from a local copy of the clip matrix and
// compared field by field against the block's output.
// ============================================================================
module box_frustum_cull_test_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS    = bfc_pkg::FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT   = 3000;  // cycles with no item moving on either side
  localparam int SETTLE_LAT   = 12;    // pipe depth plus margin after the last result
  localparam int SHOWN_ERRORS = 10;

  // One queued item: a row load or a box test, plus a flag that makes the
  // driver hold it back until every pending verdict has come out.
  typedef struct packed {
    bfc_pkg::op_t     op;
    logic [1:0]       row;
    logic [3:0][31:0] coef;
    logic [2:0][30:0] size;
    logic             drain;
  } cull_item_t;

  typedef struct packed {
    logic       visible;
    logic [5:0] plane_mask;
  } verdict_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_operation;
  logic [1:0]         in_row_index;
  logic signed [31:0] in_coef_col0;
  logic signed [31:0] in_coef_col1;
  logic signed [31:0] in_coef_col2;
  logic signed [31:0] in_coef_col3;
  logic [30:0]        in_size_x;
  logic [30:0]        in_size_y;
  logic [30:0]        in_size_z;
  logic               out_valid;
  logic               out_stall;
  logic               out_visible;
  logic [5:0]         out_plane_mask;

  box_frustum_cull_test #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_row_index   (in_row_index),
    .in_coef_col0   (in_coef_col0),
    .in_coef_col1   (in_coef_col1),
    .in_coef_col2   (in_coef_col2),
    .in_coef_col3   (in_coef_col3),
    .in_size_x      (in_size_x),
    .in_size_y      (in_size_y),
    .in_size_z      (in_size_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_visible    (out_visible),
    .out_plane_mask (out_plane_mask)
  );

  // --------------------------------------------------------------------------
  // Clock: 10 ns period.
  // --------------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  cull_item_t         pending_q[$];     // items still to be offered
  verdict_t           verdict_q[$];     // verdicts the block still owes
  logic signed [31:0] clip_mat[4][4];   // bench copy of the clip matrix
  cull_item_t         cur_item;         // item currently on the input ports
  logic               drain_next = 1'b0;
  int                 items_queued = 0;
  int                 items_taken = 0;
  int                 fail_count = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 idle_cycles = 0;
  int                 stall_mode = 0;
  int                 mode_timer = 0;
  int                 stall_phase = 0;
  int                 stall_run = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Clip coordinate of matrix row r at one box corner, held at twice its value
  // so the half extents never need a shift. Corner bit 2 flips x, bit 1 y,
  // bit 0 z. 80 bits is far more than the worst case needs.
  function automatic logic signed [79:0] clip_twice(int r, logic [2:0][30:0] sz,
                                                    int corner);
    logic signed [79:0] acc;
    logic signed [79:0] prod;
    logic signed [79:0] dim;
    int j;
    acc = clip_mat[r][3];
    acc = acc <<< (FRAC_BITS + 1);
    for (j = 0; j < 3; j++) begin
      dim  = {49'd0, sz[j]};
      prod = clip_mat[r][j];
      prod = prod * dim;
      if ((corner & (4 >> j)) != 0) acc = acc - prod;
      else acc = acc + prod;
    end
    return acc;
  endfunction

  // Plane mask over all eight corners; visible only when every plane has at
  // least one corner on its inner side.
  function automatic verdict_t box_verdict(logic [2:0][30:0] sz);
    verdict_t v;
    logic signed [79:0] w;
    logic signed [79:0] p;
    int c;
    int a;
    v.plane_mask = '0;
    for (c = 0; c < 8; c++) begin
      w = clip_twice(3, sz, c);
      for (a = 0; a < 3; a++) begin
        p = clip_twice(a, sz, c);
        if (w - p >= 0) v.plane_mask[2*a] = 1'b1;
        if (w + p >= 0) v.plane_mask[2*a+1] = 1'b1;
      end
    end
    v.visible = &v.plane_mask;
    return v;
  endfunction

  task automatic flag_error(string msg);
    if (fail_count < SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  // Signed random value in [-mag, mag].
  function automatic logic [31:0] spread(int mag);
    int t;
    t = int'($urandom_range(0, 2 * mag));
    return 32'(t - mag);
  endfunction

  task automatic push_load(logic [1:0] r, logic [31:0] c0, logic [31:0] c1,
                           logic [31:0] c2, logic [31:0] c3);
    cull_item_t it;
    it.op    = bfc_pkg::OP_LOAD;
    it.row   = r;
    it.coef  = {c3, c2, c1, c0};
    // sizes ride along on a load and must be ignored
    it.size  = {31'($urandom), 31'($urandom), 31'($urandom)};
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(it);
  endtask

  task automatic push_test(logic [30:0] sx, logic [30:0] sy, logic [30:0] sz);
    cull_item_t it;
    it.op    = bfc_pkg::OP_TEST;
    // row and coefficients are don't-care on a test
    it.row   = 2'($urandom);
    it.coef  = {$urandom, $urandom, $urandom, $urandom};
    it.size  = {sz, sy, sx};
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(it);
  endtask

  // Style 0: raw full-range row. Style 1: scale, rotate-ish and translate, with
  // an affine or perspective w row. Style 2: small coefficients near the planes.
  task automatic load_styled_row(int r, int style);
    logic [3:0][31:0] c;
    int j;
    case (style)
      0: begin
        for (j = 0; j < 4; j++) c[j] = $urandom;
      end
      1: begin
        for (j = 0; j < 4; j++) c[j] = spread(1 << 15);
        if (r < 3) begin
          c[r] = spread(4 << 16);
          c[3] = spread(4 << 16);
        end else if ($urandom_range(0, 1) == 0) begin
          c = '0;
          c[3] = 32'h0001_0000;
        end else begin
          c[0] = '0;
          c[1] = '0;
          c[2] = 32'hFFFF_0000;
          c[3] = spread(6 << 16);
        end
      end
      default: begin
        for (j = 0; j < 4; j++) c[j] = spread(1 << 17);
      end
    endcase
    push_load(2'(r), c[0], c[1], c[2], c[3]);
  endtask

  // Mostly modest boxes; a few degenerate, tiny or full-range ones.
  task automatic test_styled_box();
    logic [2:0][30:0] s;
    int sel;
    int j;
    sel = $urandom_range(0, 9);
    for (j = 0; j < 3; j++) begin
      if (sel == 0) s[j] = '0;
      else if (sel <= 6) s[j] = 31'($urandom_range(0, 8 << 16));
      else if (sel == 7) s[j] = 31'($urandom_range(0, 255));
      else s[j] = 31'($urandom);
    end
    push_test(s[0], s[1], s[2]);
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of items with random gaps; payload holds while stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // item accepted at this edge: update the matrix copy or predict a verdict
      if (in_valid && !in_stall) begin
        if (cur_item.op == bfc_pkg::OP_LOAD) begin
          for (int j = 0; j < 4; j++) clip_mat[cur_item.row][j] = cur_item.coef[j];
        end else begin
          verdict_q.push_back(box_verdict(cur_item.size));
        end
        items_taken++;
      end
      // pick what goes on the ports next, only once the port is free
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && verdict_q.size() != 0)) begin
          cur_item = pending_q.pop_front();
          in_operation <= cur_item.op;
          in_row_index <= cur_item.row;
          in_coef_col0 <= cur_item.coef[0];
          in_coef_col1 <= cur_item.coef[1];
          in_coef_col2 <= cur_item.coef[2];
          in_coef_col3 <= cur_item.coef[3];
          in_size_x    <= cur_item.size[0];
          in_size_y    <= cur_item.size[1];
          in_size_z    <= cur_item.size[2];
          in_valid     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) gap_left = 0;
            else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 40);
            else gap_left = $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: switch between no stall, a periodic pattern,
  // random stalls and long stall runs at random intervals.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_timer = $urandom_range(50, 300);
      end else begin
        mode_timer--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= (stall_phase % 5) < 2;
        2: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run != 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_run = $urandom_range(5, 30);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted verdict with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("unexpected result visible=%0d mask=%b",
                             out_visible, out_plane_mask));
      end else begin
        want = verdict_q.pop_front();
        if (out_visible !== want.visible)
          flag_error($sformatf("visible: expected %0d, got %0d",
                               want.visible, out_visible));
        if (out_plane_mask !== want.plane_mask)
          flag_error($sformatf("plane_mask: expected %b, got %b",
                               want.plane_mask, out_plane_mask));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("box_frustum_cull_test verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, build stimulus, wait for the block to drain, report.
  // --------------------------------------------------------------------------
  initial begin
    int r;
    int style;
    int ntests;
    int t;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = 1'b0;
    in_row_index = '0;
    in_coef_col0 = '0;
    in_coef_col1 = '0;
    in_coef_col2 = '0;
    in_coef_col3 = '0;
    in_size_x    = '0;
    in_size_y    = '0;
    in_size_z    = '0;
    out_stall    = 1'b0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) clip_mat[i][j] = '0;

    // Directed part.
    // Test before any load: the zero matrix puts every corner on every plane.
    push_test('0, '0, '0);
    push_test(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    // Identity matrix.
    push_load(2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    push_load(2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    push_load(2'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    push_load(2'd3, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    // Zero-size box: a point at the origin.
    push_test('0, '0, '0);
    push_test(31'h2_0000, 31'h2_0000, 31'h2_0000);
    // Push x far right: both a small box and a huge one miss the x<=w plane.
    push_load(2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    push_test(31'h1_0000, 31'h1_0000, 31'h1_0000);
    push_test(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    // Coefficient extremes.
    push_load(2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_test(31'h4000_0000, 31'h0001_2345, 31'h7FFF_0000);
    push_load(2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_test(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_load(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_test(31'h7FFF_FFFF, '0, '0);
    push_test('0, 31'h7FFF_FFFF, 31'd1);
    // w row of zero: only points exactly on the planes stay inside.
    push_load(2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    push_test('0, '0, '0);
    push_test(31'd1, 31'd1, 31'd1);

    // Random part: scenes of a full matrix load followed by box tests, with
    // partial reloads and raw full-range rows mixed in as noise.
    drain_next = 1'b1;
    while (pending_q.size() < RANDOM_ITEMS + 21) begin
      style = $urandom_range(0, 2);
      t = $urandom_range(0, 9);
      if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
      if (t < 7) begin
        for (r = 0; r < 4; r++) load_styled_row(r, style);
      end else if (t < 9) begin
        load_styled_row($urandom_range(0, 3), style);
      end else begin
        load_styled_row($urandom_range(0, 3), 0);
      end
      ntests = $urandom_range(1, 10);
      for (int k = 0; k < ntests; k++) test_styled_box();
    end
    items_queued = pending_q.size();

    // Release reset.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every item is taken and every verdict has come back.
    while (items_taken != items_queued) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_LAT) @(posedge clk);

    if (fail_count == 0) begin
      $display("box_frustum_cull_test verification clean");
    end else begin
      $display("box_frustum_cull_test verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bfc_pkg.sv
rtl/bfc_front.sv
rtl/bfc_queue.sv
rtl/bfc_back.sv
rtl/box_frustum_cull_test.sv
rtl/bfc_checker.sv
test/box_frustum_cull_test_tb.sv
